[src/elsm_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// elsm_pkg
// Shared codes, result and control types for the link state manager.
// ----------------------------------------------------------------------------
package elsm_pkg;

  // input item types
  localparam logic [1:0] REQ_MODE  = 2'd0;
  localparam logic [1:0] REQ_STACK = 2'd1;
  localparam logic [1:0] REQ_TICK  = 2'd2;
  localparam logic [1:0] REQ_QUERY = 2'd3;

  // network states
  localparam logic [2:0] ST_NOCOM      = 3'd0;
  localparam logic [2:0] ST_WAITLINK   = 3'd1;
  localparam logic [2:0] ST_WAITONLINE = 3'd2;
  localparam logic [2:0] ST_COMREADY   = 3'd3;
  localparam logic [2:0] ST_ONHOLD     = 3'd4;

  // communication modes
  localparam logic [1:0] MODE_NONE   = 2'd0;
  localparam logic [1:0] MODE_SILENT = 2'd1;
  localparam logic [1:0] MODE_FULL   = 2'd2;

  // network stack states (startup is internal only)
  localparam logic [1:0] STK_OFFLINE = 2'd0;
  localparam logic [1:0] STK_ONLINE  = 2'd1;
  localparam logic [1:0] STK_ONHOLD  = 2'd2;
  localparam logic [1:0] STK_STARTUP = 2'd3;

  // controller commands
  localparam logic [1:0] CMD_NONE = 2'd0;
  localparam logic [1:0] CMD_UP   = 2'd1;
  localparam logic [1:0] CMD_DOWN = 2'd2;

  // result status
  localparam logic [1:0] STS_OK      = 2'd0;
  localparam logic [1:0] STS_BAD_NET = 2'd1;
  localparam logic [1:0] STS_BAD_PAR = 2'd2;

  // configuration register indexes
  localparam logic [1:0] CFG_LINK_TMO   = 2'd0;
  localparam logic [1:0] CFG_ONLINE_TMO = 2'd1;
  localparam logic [1:0] CFG_TICK_INC   = 2'd2;
  localparam logic [1:0] CFG_RETRY_LIM  = 2'd3;

  localparam logic [15:0] RST_LINK_TMO   = 16'd1000;
  localparam logic [15:0] RST_ONLINE_TMO = 16'd1000;
  localparam logic [7:0]  RST_TICK_INC   = 8'd10;
  localparam logic [7:0]  RST_RETRY_LIM  = 8'd3;

  // results delivered per transaction
  localparam int RES_CNT_W = 3;
  localparam logic [RES_CNT_W-1:0] MAX_RESULTS = 3'd4;

  typedef struct packed {
    logic       kind;
    logic       net_id;
    logic [1:0] com_mode;
    logic [2:0] sm_state;
    logic [1:0] ctrl_cmd;
    logic [1:0] status;
  } res_t;

  typedef struct packed {
    logic load;       // capture the input transaction
    logic step_cmd;   // execute request, indication or query
    logic step_tick;  // execute one tick phase of the selected network
    logic phase;      // 1: second com-ready phase (link check)
    logic flush;      // release the held result as the final one
  } ctl_cmd_t;

  typedef struct packed {
    logic [1:0] req_type;
    logic       more;  // com-ready network needs the link-check phase
    logic       room;  // a result can be taken this cycle
  } ctl_sts_t;

  function automatic logic [1:0] mode_of(input logic [2:0] st);
    logic [1:0] m;
    if (st == ST_COMREADY) begin
      m = MODE_FULL;
    end else if (st == ST_NOCOM) begin
      m = MODE_NONE;
    end else begin
      m = MODE_SILENT;
    end
    return m;
  endfunction

endpackage

[src/ethernet_link_state_manager.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ethernet_link_state_manager
// Per-network Ethernet communication state manager, top level.
//
// Mode requests, stack indications and mode queries pass through capture,
// dispatch, execute and release of the final result before the block is
// ready again. For a tick, after capture and dispatch the sequencer steps one
// network phase per cycle through a shared next-state unit, with a second
// phase for each com-ready network with a pending request, then releases the
// final result; each step waits while the hold stage and the output register
// are both occupied. Results leave through a registered output, so a new
// transaction is taken while the last result still waits to be read.
// Configuration writes take effect at once and must be made while idle.
// ----------------------------------------------------------------------------
module ethernet_link_state_manager #(
  parameter int NUM_NETWORKS = 2
) (
  input  logic        clk,
  input  logic        rst,
  // configuration
  input  logic        cfg_we,
  input  logic [1:0]  cfg_addr,
  input  logic [15:0] cfg_data,
  // input channel
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  req_type,
  input  logic [7:0]  network,
  input  logic [1:0]  mode_value,
  input  logic [1:0]  link_up_bits,
  input  logic [1:0]  ctrl_ok_bits,
  // output channel
  output logic        out_valid,
  input  logic        out_ready,
  output logic        kind,
  output logic        net_id,
  output logic [1:0]  com_mode,
  output logic [2:0]  sm_state,
  output logic [1:0]  ctrl_cmd,
  output logic [1:0]  status,
  output logic        last
);

  localparam int NET_W = (NUM_NETWORKS > 1) ? $clog2(NUM_NETWORKS) : 1;

  elsm_pkg::ctl_cmd_t cmd;
  elsm_pkg::ctl_sts_t sts;
  elsm_pkg::res_t     out_res;
  logic [NET_W-1:0]   tick_net;

  elsm_ctrl #(
    .NUM_NETWORKS (NUM_NETWORKS),
    .NET_W        (NET_W)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd),
    .tick_net (tick_net)
  );

  elsm_datapath #(
    .NUM_NETWORKS (NUM_NETWORKS),
    .NET_W        (NET_W)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_addr     (cfg_addr),
    .cfg_data     (cfg_data),
    .req_type     (req_type),
    .network      (network),
    .mode_value   (mode_value),
    .link_up_bits (link_up_bits),
    .ctrl_ok_bits (ctrl_ok_bits),
    .cmd          (cmd),
    .tick_net     (tick_net),
    .sts          (sts),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_res      (out_res),
    .out_last     (last)
  );

  assign kind     = out_res.kind;
  assign net_id   = out_res.net_id;
  assign com_mode = out_res.com_mode;
  assign sm_state = out_res.sm_state;
  assign ctrl_cmd = out_res.ctrl_cmd;
  assign status   = out_res.status;

endmodule

[src/elsm_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// elsm_ctrl
// Sequencer: accepts a transaction, dispatches it and walks the networks on a
// tick, one phase per cycle, waiting for output room before each step.
// ----------------------------------------------------------------------------
module elsm_ctrl #(
  parameter int NUM_NETWORKS = 2,
  parameter int NET_W        = 1
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  elsm_pkg::ctl_sts_t  sts,
  output elsm_pkg::ctl_cmd_t  cmd,
  output logic [NET_W-1:0]    tick_net
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DISPATCH,
    S_CMD,
    S_TICK,
    S_FLUSH
  } state_t;

  state_t state;
  logic   phase;
  logic   last_net;

  assign last_net = (tick_net == NET_W'(NUM_NETWORKS - 1));
  assign in_ready = (state == S_IDLE);

  always_comb begin
    cmd           = '0;
    cmd.phase     = phase;
    cmd.load      = (state == S_IDLE) && in_valid;
    cmd.step_cmd  = (state == S_CMD) && sts.room;
    cmd.step_tick = (state == S_TICK) && sts.room;
    cmd.flush     = (state == S_FLUSH) && sts.room;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      phase    <= 1'b0;
      tick_net <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            state <= S_DISPATCH;
          end
        end
        S_DISPATCH: begin
          phase    <= 1'b0;
          tick_net <= '0;
          if (sts.req_type == elsm_pkg::REQ_TICK) begin
            state <= S_TICK;
          end else begin
            state <= S_CMD;
          end
        end
        S_CMD: begin
          if (sts.room) begin
            state <= S_FLUSH;
          end
        end
        S_TICK: begin
          if (sts.room) begin
            if (sts.more) begin
              phase <= 1'b1;
            end else if (last_net) begin
              phase <= 1'b0;
              state <= S_FLUSH;
            end else begin
              phase    <= 1'b0;
              tick_net <= tick_net + NET_W'(1);
            end
          end
        end
        S_FLUSH: begin
          if (sts.room) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

[src/elsm_datapath.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// elsm_datapath
// Per-network state, configuration registers, the next-state logic of one
// network step, a one-deep hold stage and the output register.
// ----------------------------------------------------------------------------
module elsm_datapath #(
  parameter int NUM_NETWORKS = 2,
  parameter int NET_W        = 1
) (
  input  logic               clk,
  input  logic               rst,
  // configuration
  input  logic               cfg_we,
  input  logic [1:0]         cfg_addr,
  input  logic [15:0]        cfg_data,
  // input payload
  input  logic [1:0]         req_type,
  input  logic [7:0]         network,
  input  logic [1:0]         mode_value,
  input  logic [1:0]         link_up_bits,
  input  logic [1:0]         ctrl_ok_bits,
  // control
  input  elsm_pkg::ctl_cmd_t cmd,
  input  logic [NET_W-1:0]   tick_net,
  output elsm_pkg::ctl_sts_t sts,
  // results
  output logic               out_valid,
  input  logic               out_ready,
  output elsm_pkg::res_t     out_res,
  output logic               out_last
);

  // configuration
  logic [15:0] link_tmo;
  logic [15:0] online_tmo;
  logic [7:0]  tick_inc;
  logic [7:0]  retry_lim;

  // latched transaction
  logic [1:0] it_type;
  logic [7:0] it_net;
  logic [1:0] it_mode;
  logic [1:0] it_link;
  logic [1:0] it_ok;

  // per-network state
  logic [2:0]  net_state      [NUM_NETWORKS];
  logic [1:0]  requested_mode [NUM_NETWORKS];
  logic [1:0]  current_mode   [NUM_NETWORKS];
  logic [1:0]  stack_state    [NUM_NETWORKS];
  logic [15:0] wait_counter   [NUM_NETWORKS];
  logic [7:0]  retry_count    [NUM_NETWORKS];

  // hold stage and result count
  logic                             pend_valid;
  elsm_pkg::res_t                   pend_res;
  logic [elsm_pkg::RES_CNT_W-1:0]   res_cnt;

  // step logic
  logic [NET_W-1:0] rd;
  logic             net_ok;
  logic             link;
  logic             ok;
  logic [2:0]       st;
  logic [2:0]       st_next;
  logic [1:0]       req_next;
  logic [1:0]       cur_next;
  logic [1:0]       stk_next;
  logic [15:0]      wc_next;
  logic [7:0]       rc_next;
  logic             wr;
  logic             emit;
  logic             do_go;
  logic [2:0]       go_st;
  logic [1:0]       go_cmd;
  logic [16:0]      grown;
  logic [15:0]      grown_sat;
  logic             step;
  logic             out_free;
  logic             emit_ok;
  elsm_pkg::res_t   res;

  assign step     = cmd.step_cmd || cmd.step_tick;
  assign out_free = !out_valid || out_ready;
  assign emit_ok  = step && emit && (res_cnt < elsm_pkg::MAX_RESULTS);

  assign sts.req_type = it_type;
  assign sts.room     = !pend_valid || out_free;
  assign sts.more     = !cmd.phase && (st == elsm_pkg::ST_COMREADY) &&
                        (requested_mode[rd] != elsm_pkg::MODE_NONE);

  always_comb begin
    rd     = cmd.step_tick ? tick_net : it_net[NET_W-1:0];
    net_ok = (it_net < 8'(NUM_NETWORKS));
    // only networks 0 and 1 have tick bits
    link   = (int'(tick_net) < 2) && it_link[tick_net[0]];
    ok     = (int'(tick_net) < 2) && it_ok[tick_net[0]];
    st     = net_state[rd];

    st_next  = st;
    req_next = requested_mode[rd];
    cur_next = current_mode[rd];
    stk_next = stack_state[rd];
    wc_next  = wait_counter[rd];
    rc_next  = retry_count[rd];
    wr       = 1'b0;
    emit     = 1'b0;
    do_go    = 1'b0;
    go_st    = elsm_pkg::ST_NOCOM;
    go_cmd   = elsm_pkg::CMD_NONE;
    res      = '0;

    grown     = {1'b0, wait_counter[rd]} + 17'(tick_inc);
    grown_sat = grown[16] ? 16'hFFFF : grown[15:0];

    if (cmd.step_tick) begin
      wr = 1'b1;
      if (cmd.phase) begin
        if (!link) begin
          do_go = 1'b1;
          go_st = elsm_pkg::ST_WAITLINK;
        end
      end else if (st > elsm_pkg::ST_ONHOLD) begin
        st_next = elsm_pkg::ST_NOCOM;
      end else if (st == elsm_pkg::ST_NOCOM) begin
        if (requested_mode[rd] == elsm_pkg::MODE_FULL) begin
          if (ok) begin
            do_go  = 1'b1;
            go_st  = elsm_pkg::ST_WAITLINK;
            go_cmd = elsm_pkg::CMD_UP;
          end else begin
            rc_next = retry_count[rd] + 8'd1;
            if (rc_next >= retry_lim) begin
              rc_next  = '0;
              req_next = elsm_pkg::MODE_NONE;
            end
          end
        end else begin
          rc_next = '0;
        end
      end else if (requested_mode[rd] == elsm_pkg::MODE_NONE) begin
        do_go  = 1'b1;
        go_st  = elsm_pkg::ST_NOCOM;
        go_cmd = elsm_pkg::CMD_DOWN;
      end else begin
        unique case (st)
          elsm_pkg::ST_WAITLINK: begin
            if (link) begin
              stk_next = elsm_pkg::STK_STARTUP;
              do_go    = 1'b1;
              go_st    = elsm_pkg::ST_WAITONLINE;
            end else begin
              wc_next = grown_sat;
              if (grown_sat >= link_tmo) begin
                do_go    = 1'b1;
                go_st    = elsm_pkg::ST_NOCOM;
                go_cmd   = elsm_pkg::CMD_DOWN;
                req_next = elsm_pkg::MODE_NONE;
              end
            end
          end
          elsm_pkg::ST_WAITONLINE: begin
            if (stack_state[rd] == elsm_pkg::STK_ONLINE) begin
              do_go = 1'b1;
              go_st = elsm_pkg::ST_COMREADY;
            end else if (stack_state[rd] == elsm_pkg::STK_OFFLINE) begin
              do_go = 1'b1;
              go_st = elsm_pkg::ST_WAITLINK;
            end else begin
              wc_next = grown_sat;
              if (grown_sat >= online_tmo) begin
                do_go    = 1'b1;
                go_st    = elsm_pkg::ST_NOCOM;
                go_cmd   = elsm_pkg::CMD_DOWN;
                req_next = elsm_pkg::MODE_NONE;
              end
            end
          end
          elsm_pkg::ST_ONHOLD: begin
            if (stack_state[rd] == elsm_pkg::STK_ONLINE) begin
              do_go = 1'b1;
              go_st = elsm_pkg::ST_COMREADY;
            end else if (stack_state[rd] == elsm_pkg::STK_OFFLINE) begin
              do_go = 1'b1;
              go_st = elsm_pkg::ST_WAITLINK;
            end
          end
          default: begin
            // com-ready; the link check follows in the next phase
            if (stack_state[rd] == elsm_pkg::STK_ONHOLD) begin
              do_go = 1'b1;
              go_st = elsm_pkg::ST_ONHOLD;
            end else if (stack_state[rd] == elsm_pkg::STK_OFFLINE) begin
              do_go = 1'b1;
              go_st = elsm_pkg::ST_WAITLINK;
            end
          end
        endcase
      end

      if (do_go) begin
        st_next      = go_st;
        wc_next      = '0;
        cur_next     = elsm_pkg::mode_of(go_st);
        emit         = 1'b1;
        res.kind     = 1'b1;
        res.net_id   = rd[0];
        res.com_mode = elsm_pkg::mode_of(go_st);
        res.sm_state = go_st;
        res.ctrl_cmd = go_cmd;
        res.status   = elsm_pkg::STS_OK;
      end
    end else begin
      // request, indication or query on the latched network
      if (net_ok) begin
        res.net_id   = it_net[0];
        res.com_mode = current_mode[rd];
        res.sm_state = st;
      end
      unique case (it_type)
        elsm_pkg::REQ_MODE: begin
          emit = 1'b1;
          if (!net_ok) begin
            res.status = elsm_pkg::STS_BAD_NET;
          end else if (it_mode > elsm_pkg::MODE_FULL) begin
            res.status = elsm_pkg::STS_BAD_PAR;
          end else begin
            wr       = 1'b1;
            req_next = it_mode;
            rc_next  = '0;
          end
        end
        elsm_pkg::REQ_STACK: begin
          if (net_ok && (it_mode <= elsm_pkg::STK_ONHOLD)) begin
            wr       = 1'b1;
            stk_next = it_mode;
          end
        end
        elsm_pkg::REQ_QUERY: begin
          emit = 1'b1;
          if (!net_ok) begin
            res.status = elsm_pkg::STS_BAD_NET;
          end
        end
        default: begin
          emit = 1'b0;
        end
      endcase
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      link_tmo   <= elsm_pkg::RST_LINK_TMO;
      online_tmo <= elsm_pkg::RST_ONLINE_TMO;
      tick_inc   <= elsm_pkg::RST_TICK_INC;
      retry_lim  <= elsm_pkg::RST_RETRY_LIM;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        elsm_pkg::CFG_LINK_TMO:   link_tmo   <= cfg_data;
        elsm_pkg::CFG_ONLINE_TMO: online_tmo <= cfg_data;
        elsm_pkg::CFG_TICK_INC:   tick_inc   <= cfg_data[7:0];
        elsm_pkg::CFG_RETRY_LIM:  retry_lim  <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // transaction capture
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      it_type <= req_type;
      it_net  <= network;
      it_mode <= mode_value;
      it_link <= link_up_bits;
      it_ok   <= ctrl_ok_bits;
    end
  end

  // per-network state
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_NETWORKS; i++) begin
        net_state[i]      <= elsm_pkg::ST_NOCOM;
        requested_mode[i] <= elsm_pkg::MODE_NONE;
        current_mode[i]   <= elsm_pkg::MODE_NONE;
        stack_state[i]    <= elsm_pkg::STK_OFFLINE;
        wait_counter[i]   <= '0;
        retry_count[i]    <= '0;
      end
    end else if (step && wr) begin
      net_state[rd]      <= st_next;
      requested_mode[rd] <= req_next;
      current_mode[rd]   <= cur_next;
      stack_state[rd]    <= stk_next;
      wait_counter[rd]   <= wc_next;
      retry_count[rd]    <= rc_next;
    end
  end

  // hold stage and output register: a result waits in the hold stage until
  // the next one (not last) or the flush (last) pushes it out
  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
      out_valid  <= 1'b0;
      res_cnt    <= '0;
    end else begin
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      if (cmd.load) begin
        res_cnt <= '0;
      end
      if (emit_ok) begin
        res_cnt    <= res_cnt + elsm_pkg::RES_CNT_W'(1);
        pend_valid <= 1'b1;
        if (pend_valid) begin
          out_valid <= 1'b1;
        end
      end else if (cmd.flush && pend_valid) begin
        pend_valid <= 1'b0;
        out_valid  <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit_ok) begin
      pend_res <= res;
      if (pend_valid) begin
        out_res  <= pend_res;
        out_last <= 1'b0;
      end
    end else if (cmd.flush && pend_valid) begin
      out_res  <= pend_res;
      out_last <= 1'b1;
    end
  end

endmodule

[src/elsm_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// elsm_checker
// Port-level checks on the link state manager, bound to the top level.
// ----------------------------------------------------------------------------
module elsm_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic       kind,
  input logic [1:0] com_mode,
  input logic [2:0] sm_state,
  input logic [1:0] ctrl_cmd,
  input logic [1:0] status,
  input logic       last
);

  // one transaction at a time: ready drops right after an accept
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted while a transaction is in progress");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(kind) && $stable(status) &&
      $stable(com_mode) && $stable(sm_state) && $stable(ctrl_cmd) && $stable(last))
    else $error("result changed while stalled");

  // notifications are always ok; answers never carry a controller command
  a_result_codes: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (kind ? (status == elsm_pkg::STS_OK)
                        : (ctrl_cmd == elsm_pkg::CMD_NONE)) &&
                  (com_mode != 2'd3) && (sm_state <= elsm_pkg::ST_ONHOLD))
    else $error("result fields out of range");

  // reset leaves nothing to deliver
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid && in_ready)
    else $error("result or busy state survived reset");

endmodule

bind ethernet_link_state_manager elsm_checker u_elsm_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .kind      (kind),
  .com_mode  (com_mode),
  .sm_state  (sm_state),
  .ctrl_cmd  (ctrl_cmd),
  .status    (status),
  .last      (last)
);
